>>> hdl/mkkeg_pkg.sv
// Shared types, constants and helper functions for the key and knob event generator.
package mkkeg_pkg;

	// Number of analog knob channels in the rotation and the sample width.
	localparam int ANALOG_CHANNELS = 8;
	localparam int SAMPLE_BITS = 10;
	localparam int CH_W = (ANALOG_CHANNELS > 1) ? $clog2(ANALOG_CHANNELS) : 1;
	localparam logic [CH_W-1:0] CH_RESET = (6 < ANALOG_CHANNELS) ? CH_W'(6) : '0;

	// Register map, one word per register.
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_FIRST_CH = 2'd1;
	localparam logic [1:0] REG_CTRL_BASE = 2'd2;
	localparam logic [1:0] REG_VELOCITY = 2'd3;

	localparam logic [9:0] THRESHOLD_RESET = 10'd7;
	localparam logic [2:0] FIRST_CH_RESET = 3'd6;
	localparam logic [6:0] CTRL_BASE_RESET = 7'd70;
	localparam logic [6:0] VELOCITY_RESET = 7'd127;

	// Event packet codes: cable code index and status byte.
	localparam logic [7:0] CIN_NOTE_OFF = 8'h08;
	localparam logic [7:0] ST_NOTE_OFF = 8'h80;
	localparam logic [7:0] CIN_NOTE_ON = 8'h09;
	localparam logic [7:0] ST_NOTE_ON = 8'h90;
	localparam logic [7:0] CIN_CONTROL = 8'h0b;
	localparam logic [7:0] ST_CONTROL = 8'hb0;
	localparam logic [6:0] NOTE_NONE = 7'd0;

	typedef struct packed {
		logic [7:0] key_lines;
		logic       link_ready;
		logic [9:0] adc_value;
	} poll_t;

	typedef struct packed {
		logic [31:0] first_event;
		logic [31:0] second_event;
		logic [1:0]  event_count;
		logic        empty_frame_follows;
		logic [2:0]  next_channel;
	} event_t;

	// Lowest pressed key (active low) mapped onto the C major scale.
	function automatic logic [6:0] lowest_note(input logic [7:0] lines);
		logic [6:0] note;
		note = NOTE_NONE;
		priority casez (lines)
			8'b???????0: note = 7'd60;
			8'b??????01: note = 7'd62;
			8'b?????011: note = 7'd64;
			8'b????0111: note = 7'd65;
			8'b???01111: note = 7'd67;
			8'b??011111: note = 7'd69;
			8'b?0111111: note = 7'd71;
			8'b01111111: note = 7'd72;
			default:     note = NOTE_NONE;
		endcase
		return note;
	endfunction

	// Assemble one four-byte event packet.
	function automatic logic [31:0] make_packet(input logic [7:0] cin, input logic [7:0] status,
			input logic [6:0] d1, input logic [6:0] d2);
		return {cin, status, 1'b0, d1, 1'b0, d2};
	endfunction

endpackage

>>> hdl/midi_key_and_knob_event_generator.sv
// Top level of the key and knob event generator: poll decode, state and result register.
//
// Usage: each request on the input channel (in_valid/in_ready, payload in_data) is one poll
// of the eight active-low key lines, the link-ready flag and one ADC sample. The sample must
// belong to the channel reported in next_channel of the previous result. Each request gives
// exactly one result on the output channel (out_valid/out_ready, payload out_data) with zero,
// one or two event packets.
// The result is registered: a request accepted at one edge shows its result after that edge.
// Throughput is one request per cycle while the receiver takes every result; the key decode,
// the hysteresis compare against the stored sample and the packet assembly all fit between
// the state registers and the result register.
// When the receiver stalls, the result register holds its request and in_ready follows
// out_ready, so a new request is taken in the same cycle the held result leaves.
// Reset clears the held note and pending flag, sets every stored sample to minus one,
// starts the rotation at channel six and loads the register defaults. No clearing pass.
// Configuration goes through the APB port at byte addresses 0, 4, 8 and 12 and should only
// be written while no request is in flight.
module midi_key_and_knob_event_generator (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  mkkeg_pkg::poll_t      in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mkkeg_pkg::event_t     out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import mkkeg_pkg::*;

	localparam int DIFF_W = SAMPLE_BITS + 2;

	logic [9:0]  threshold_q;
	logic [2:0]  first_ch_q;
	logic [6:0]  ctrl_base_q;
	logic [6:0]  velocity_q;

	logic [6:0]  held_note_q;
	logic        pending_q;
	logic signed [SAMPLE_BITS:0] last_q [ANALOG_CHANNELS];
	logic [CH_W-1:0] chan_q;

	event_t      out_q;
	logic        out_valid_q;

	logic        in_fire;
	logic        cfg_write;
	logic [6:0]  note;
	logic        pend;
	logic [SAMPLE_BITS-1:0] sample;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0] mag;
	logic        exceed;
	logic [CH_W-1:0] wrap_ch;
	logic [CH_W-1:0] chan_inc;
	logic [6:0]  controller;

	logic [6:0]  held_note_d;
	logic        pending_d;
	logic [CH_W-1:0] chan_d;
	logic        store_sample;
	event_t      result;

	assign in_fire = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			first_ch_q <= FIRST_CH_RESET;
			ctrl_base_q <= CTRL_BASE_RESET;
			velocity_q <= VELOCITY_RESET;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_THRESHOLD: threshold_q <= pwdata[9:0];
				REG_FIRST_CH:  first_ch_q <= pwdata[2:0];
				REG_CTRL_BASE: ctrl_base_q <= pwdata[6:0];
				REG_VELOCITY:  velocity_q <= pwdata[6:0];
				default:       threshold_q <= threshold_q;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[3:2])
			REG_THRESHOLD: prdata = {22'd0, threshold_q};
			REG_FIRST_CH:  prdata = {29'd0, first_ch_q};
			REG_CTRL_BASE: prdata = {25'd0, ctrl_base_q};
			REG_VELOCITY:  prdata = {25'd0, velocity_q};
			default:       prdata = '0;
		endcase
	end

	// Key decode and hysteresis compare for the current channel.
	always_comb begin
		note = lowest_note(in_data.key_lines);
		pend = pending_q || (note != held_note_q);
		sample = in_data.adc_value[SAMPLE_BITS-1:0];
		diff = DIFF_W'(last_q[chan_q]) - $signed({2'b00, sample});
		mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		exceed = mag > DIFF_W'(threshold_q);
		wrap_ch = (int'(first_ch_q) < ANALOG_CHANNELS) ? CH_W'(first_ch_q) : '0;
		chan_inc = (int'(chan_q) == ANALOG_CHANNELS - 1) ? wrap_ch : CH_W'(chan_q + 1'b1);
		controller = ctrl_base_q + 7'(chan_q);
	end

	// Event selection and next state.
	always_comb begin
		held_note_d = held_note_q;
		pending_d = pend;
		chan_d = chan_q;
		store_sample = 1'b0;
		result = '0;
		if (in_data.link_ready) begin
			if (pend) begin
				pending_d = 1'b0;
				held_note_d = note;
				if (held_note_q != NOTE_NONE) begin
					result.first_event = make_packet(CIN_NOTE_OFF, ST_NOTE_OFF, held_note_q, 7'd0);
					if (note != NOTE_NONE) begin
						result.second_event = make_packet(CIN_NOTE_ON, ST_NOTE_ON, note,
							velocity_q);
						result.event_count = 2'd2;
					end else begin
						result.event_count = 2'd1;
					end
				end else if (note != NOTE_NONE) begin
					result.first_event = make_packet(CIN_NOTE_ON, ST_NOTE_ON, note, velocity_q);
					result.event_count = 2'd1;
				end
			end else begin
				chan_d = chan_inc;
				if (exceed) begin
					store_sample = 1'b1;
					result.first_event = make_packet(CIN_CONTROL, ST_CONTROL, controller,
						sample[SAMPLE_BITS-1 -: 7]);
					result.event_count = 2'd1;
				end
			end
		end
		result.empty_frame_follows = (result.event_count == 2'd2);
		result.next_channel = 3'(chan_d);
	end

	// Poll state updates on each accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_note_q <= NOTE_NONE;
			pending_q <= 1'b0;
			chan_q <= CH_RESET;
			for (int i = 0; i < ANALOG_CHANNELS; i++) begin
				last_q[i] <= '1;
			end
		end else if (in_fire) begin
			held_note_q <= held_note_d;
			pending_q <= pending_d;
			chan_q <= chan_d;
			if (store_sample) begin
				last_q[chan_q] <= $signed({1'b0, sample});
			end
		end
	end

	// Result register: valid flag under reset, payload loads on accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_q <= result;
		end
	end

endmodule

>>> hdl/mkkeg_checker.sv
// Port-level checker for the key and knob event generator, with its bind statement.
module mkkeg_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  mkkeg_pkg::poll_t      in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  mkkeg_pkg::event_t     out_data
);
	import mkkeg_pkg::*;

	// A stalled result keeps its valid and its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// The extra empty frame is flagged exactly for two-packet results.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.empty_frame_follows == (out_data.event_count == 2'd2))
			&& (out_data.event_count != 2'd3))
		else $error("event count and empty frame flag disagree");

	// Unused packet slots are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.event_count != 2'd2) |-> (out_data.second_event == 32'd0)
			&& ((out_data.event_count != 2'd0) || (out_data.first_event == 32'd0)))
		else $error("unused event packet not zero");

	// A poll with the link busy gives an empty result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_data.link_ready |=> out_valid
			&& (out_data.event_count == 2'd0))
		else $error("events sent while link not ready");

	// A poll with the link busy does not move the channel rotation.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_valid && !in_data.link_ready
			|=> $past(out_data.next_channel) == out_data.next_channel)
		else $error("channel rotated while link not ready");

endmodule

bind midi_key_and_knob_event_generator mkkeg_checker u_mkkeg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
